@@ design/adaptive_binary_arith_encoder_defines.svh @@
// Assertion macros used by the encoder back end (abae_back).
`ifndef ADAPTIVE_BINARY_ARITH_ENCODER_DEFINES_SVH
`define ADAPTIVE_BINARY_ARITH_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define ABAE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ABAE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ABAE_ASSERT(lbl, prop, msg)
`define ABAE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ design/abae_pkg.sv @@
`default_nettype none
package abae_pkg;

    localparam int RANGE_BITS = 24;
    localparam int LOW_W      = RANGE_BITS + 8;
    localparam int CNT_W      = $clog2(RANGE_BITS + 1);

    localparam logic [RANGE_BITS-1:0] RANGE_MASK = '1;
    localparam logic [RANGE_BITS-1:0] WIDTH_INIT = RANGE_BITS'(255);
    localparam logic [RANGE_BITS-1:0] RENORM_MIN = RANGE_BITS'(128);
    localparam logic [15:0]           SPLIT_SCALE = 16'd175;
    localparam logic [7:0]            COUNT_HALF  = 8'd127;
    localparam logic [23:0]           LIMIT_INIT  = 24'hFFFFFF;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_LIMIT    = 2'd1;
    localparam logic [1:0] STAT_SHORT    = 2'd2;
    localparam logic [1:0] STAT_COLLAPSE = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] coded_byte;
        logic       byte_valid;
        logic       run_last;
        logic       stream_end;
        logic [1:0] status;
    } t_out;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       short_in;
    } t_cmd;

endpackage
`default_nettype wire

@@ design/abae_front.sv @@
`default_nettype none
module abae_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire abae_pkg::t_in   i_in,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output abae_pkg::t_cmd       o_cmd,
    output logic                 o_cmd_valid,
    input  wire logic            i_cmd_ready
);

    abae_pkg::t_cmd r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] r_br;
    logic [1:0] br_new;
    logic       push, pop;

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign br_new      = (r_br == 2'd3) ? 2'd3 : r_br + 2'd1;

    // A stream that ends before its third word is flagged here; the count
    // restarts after every last word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_br  <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= '{data_byte: i_in.data_byte, last_byte: i_in.last_byte,
                               short_in: i_in.last_byte && (br_new != 2'd3)};
                r_wp      <= ~r_wp;
                r_br      <= i_in.last_byte ? 2'd0 : br_new;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

@@ design/abae_back.sv @@
`default_nettype none
`include "adaptive_binary_arith_encoder_defines.svh"
module abae_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire abae_pkg::t_cmd  i_cmd,
    input  wire logic            i_cmd_valid,
    output logic                 o_cmd_ready,
    input  wire logic [23:0]     i_out_limit,
    output abae_pkg::t_out       o_out,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready
);

    localparam int RB = abae_pkg::RANGE_BITS;
    localparam int LW = abae_pkg::LOW_W;
    localparam int CW = abae_pkg::CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_SETUP, ST_DIV, ST_APPLY, ST_RENORM,
        ST_TAIL, ST_FLUSH, ST_FAULT, ST_FINISH
    } t_state;

    function automatic logic [15:0] bump(input logic [15:0] pair, input logic bit_v);
        logic [7:0] z, o;
        z = pair[15:8];
        o = pair[7:0];
        if (bit_v) begin
            if (o != 8'hFF) o = o + 8'd1;
            else begin
                o = abae_pkg::COUNT_HALF;
                z = z >> 1;
            end
        end else begin
            if (z != 8'hFF) z = z + 8'd1;
            else begin
                z = abae_pkg::COUNT_HALF;
                o = o >> 1;
            end
        end
        return {z, o};
    endfunction

    logic [15:0] mem [256];
    logic [15:0] r_rd;

    t_state r_state, n_state;
    abae_pkg::t_cmd r_cmd, n_cmd;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_node, n_node;
    logic        r_rd_vld, n_rd_vld;
    logic [255:0] r_ctx_vld, n_ctx_vld;
    logic [15:0] r_pair, n_pair;
    logic        r_pos, n_pos;
    logic [8:0]  r_rem, n_rem;
    logic [7:0]  r_dvd, n_dvd;
    logic [7:0]  r_quo, n_quo;
    logic [9:0]  r_div_n, n_div_n;
    logic [1:0]  r_div_cnt, n_div_cnt;
    logic [LW-1:0] r_low, n_low;
    logic [RB-1:0] r_width, n_width;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [23:0] r_bw, n_bw;
    logic        r_fault_seen, n_fault_seen;
    logic [1:0]  r_fstat, n_fstat;
    logic        r_clr_end, n_clr_end;
    logic        r_fs_end, n_fs_end;
    logic [LW-1:0] r_flush_v, n_flush_v;
    logic [1:0]  r_flush_k, n_flush_k;
    abae_pkg::t_out r_pend, n_pend;
    logic        r_pend_v, n_pend_v;
    abae_pkg::t_out r_out, n_out;
    logic        r_out_v, n_out_v;

    logic        mem_we;
    logic [15:0] mem_wd;
    logic        out_free, can_push, push_req;
    abae_pkg::t_out push_item;

    logic [15:0] pair_c;
    logic [7:0]  z_c, o_c;
    logic [8:0]  m_c;
    logic [15:0] dvd_c;
    logic [8:0]  rem_v;
    logic [9:0]  t_v;
    logic [7:0]  dvd_v, quo_v;
    logic [7:0]  mag_c;
    logic        bit_c, take_hi;
    logic [RB-1:0] w2, rest;
    logic [LW-1:0] l2, l3;
    logic [CW-1:0] negc;
    logic [3:0]  amt;

    assign out_free    = !r_out_v || i_out_ready;
    assign can_push    = !r_pend_v || out_free;
    assign o_out       = r_out;
    assign o_out_valid = r_out_v;

    always_comb begin
        n_state = r_state;   n_cmd = r_cmd;       n_bit = r_bit;
        n_node = r_node;     n_rd_vld = r_ctx_vld[r_node];
        n_ctx_vld = r_ctx_vld;
        n_pair = r_pair;     n_pos = r_pos;       n_rem = r_rem;
        n_dvd = r_dvd;       n_quo = r_quo;       n_div_n = r_div_n;
        n_div_cnt = r_div_cnt;
        n_low = r_low;       n_width = r_width;   n_cnt = r_cnt;
        n_bw = r_bw;         n_fault_seen = r_fault_seen;
        n_fstat = r_fstat;   n_clr_end = r_clr_end; n_fs_end = r_fs_end;
        n_flush_v = r_flush_v; n_flush_k = r_flush_k;
        n_pend = r_pend;     n_pend_v = r_pend_v;
        n_out = r_out;       n_out_v = r_out_v;
        o_cmd_ready = 1'b0;
        mem_we = 1'b0;
        mem_wd = '0;
        push_req = 1'b0;
        push_item = '0;

        pair_c = r_rd_vld ? r_rd : 16'd0;
        z_c    = pair_c[15:8];
        o_c    = pair_c[7:0];
        m_c    = (z_c < o_c) ? {1'b0, z_c} + 9'd1 : {1'b0, o_c} + 9'd1;
        dvd_c  = 16'(abae_pkg::SPLIT_SCALE * {7'd0, m_c});

        rem_v = r_rem;
        dvd_v = r_dvd;
        quo_v = r_quo;
        t_v   = '0;
        for (int i = 0; i < 2; i++) begin
            t_v = {rem_v, dvd_v[7]};
            if (t_v >= r_div_n) begin
                rem_v = 9'(t_v - r_div_n);
                quo_v = {quo_v[6:0], 1'b1};
            end else begin
                rem_v = t_v[8:0];
                quo_v = {quo_v[6:0], 1'b0};
            end
            dvd_v = {dvd_v[6:0], 1'b0};
        end

        mag_c   = (r_quo == 8'd0) ? 8'd1 : r_quo;
        bit_c   = r_cmd.data_byte[r_bit];
        take_hi = r_pos ? !bit_c : bit_c;
        w2      = r_width << 1;
        l2      = r_low << 1;
        l3      = {8'd0, l2[RB-1:0]};
        rest    = abae_pkg::RANGE_MASK - l2[RB-1:0];
        negc    = ~r_cnt + 1'b1;
        amt     = 4'd8 - {1'b0, negc[2:0]};

        if (r_out_v && i_out_ready) n_out_v = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_ready = 1'b1;
                    n_cmd = i_cmd;
                    if (r_fault_seen) begin
                        if (i_cmd.last_byte) begin
                            n_clr_end = 1'b1;
                            n_state = ST_FINISH;
                        end
                    end else if (i_cmd.short_in) begin
                        n_fstat = abae_pkg::STAT_SHORT;
                        n_state = ST_FAULT;
                    end else begin
                        n_bit = 3'd7;
                        n_node = 8'd1;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: n_state = ST_SETUP;
            ST_SETUP: begin
                n_pair = pair_c;
                n_pos = (z_c < o_c);
                n_rem = {1'b0, dvd_c[15:8]};
                n_dvd = dvd_c[7:0];
                n_quo = '0;
                n_div_n = {2'd0, z_c} + {2'd0, o_c} + 10'd2;
                n_div_cnt = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = rem_v;
                n_dvd = dvd_v;
                n_quo = quo_v;
                n_div_cnt = r_div_cnt + 2'd1;
                if (r_div_cnt == 2'd3) n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (r_width <= RB'(mag_c)) begin
                    n_fstat = abae_pkg::STAT_COLLAPSE;
                    n_state = ST_FAULT;
                end else begin
                    if (take_hi) begin
                        n_low = r_low + LW'(r_width - RB'(mag_c));
                        n_width = RB'(mag_c);
                    end else begin
                        n_width = r_width - RB'(mag_c);
                    end
                    mem_we = 1'b1;
                    mem_wd = bump(r_pair, bit_c);
                    n_ctx_vld[r_node] = 1'b1;
                    n_node = {r_node[6:0], bit_c};
                    n_state = ST_RENORM;
                end
            end
            ST_RENORM: begin
                if (r_width >= abae_pkg::RENORM_MIN) begin
                    if (r_bit == 3'd0) begin
                        n_state = r_cmd.last_byte ? ST_TAIL : ST_FINISH;
                    end else begin
                        n_bit = r_bit - 3'd1;
                        n_state = ST_READ;
                    end
                end else if (r_width == '0) begin
                    n_fstat = abae_pkg::STAT_COLLAPSE;
                    n_state = ST_FAULT;
                end else if (r_cnt == CW'(1)) begin
                    // Shift count runs out: a coded word leaves the top of the low end.
                    if (r_bw >= i_out_limit) begin
                        n_fstat = abae_pkg::STAT_LIMIT;
                        n_state = ST_FAULT;
                    end else if (can_push) begin
                        push_req = 1'b1;
                        push_item = '{coded_byte: l2[LW-1:RB], byte_valid: 1'b1,
                                      run_last: 1'b0, stream_end: 1'b0,
                                      status: abae_pkg::STAT_OK};
                        n_bw = r_bw + 24'd1;
                        n_low = l3;
                        n_width = (rest < w2) ? rest : w2;
                        n_cnt = CW'(8);
                    end
                end else begin
                    n_low = l2;
                    n_width = w2;
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ST_TAIL: begin
                if (r_bw >= i_out_limit || (i_out_limit - r_bw) < 24'd4) begin
                    n_fstat = abae_pkg::STAT_LIMIT;
                    n_state = ST_FAULT;
                end else begin
                    n_flush_v = r_low << amt;
                    n_flush_k = '0;
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (can_push) begin
                    push_req = 1'b1;
                    push_item = '{coded_byte: r_flush_v[RB+7:RB], byte_valid: 1'b1,
                                  run_last: 1'b0, stream_end: (r_flush_k == 2'd3),
                                  status: abae_pkg::STAT_OK};
                    n_flush_v = r_flush_v << 8;
                    n_flush_k = r_flush_k + 2'd1;
                    if (r_flush_k == 2'd3) begin
                        n_clr_end = 1'b1;
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FAULT: begin
                if (can_push) begin
                    push_req = 1'b1;
                    push_item = '{coded_byte: 8'd0, byte_valid: 1'b0, run_last: 1'b0,
                                  stream_end: 1'b1, status: r_fstat};
                    if (r_cmd.last_byte) n_clr_end = 1'b1;
                    else n_fs_end = 1'b1;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_out = r_pend;
                        n_out.run_last = 1'b1;
                        n_out_v = 1'b1;
                        n_pend_v = 1'b0;
                    end
                    if (r_clr_end) begin
                        n_ctx_vld = '0;
                        n_low = '0;
                        n_width = abae_pkg::WIDTH_INIT;
                        n_cnt = CW'(RB);
                        n_bw = '0;
                        n_fault_seen = 1'b0;
                    end
                    if (r_fs_end) n_fault_seen = 1'b1;
                    n_clr_end = 1'b0;
                    n_fs_end = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // The newest result is held back one step so that run_last can be
        // set on it when the word turns out to cause nothing more.
        if (push_req) begin
            if (r_pend_v) begin
                n_out = r_pend;
                n_out_v = 1'b1;
            end
            n_pend = push_item;
            n_pend_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_node] <= mem_wd;
        end
        r_rd <= mem[r_node];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ctx_vld    <= '0;
            r_low        <= '0;
            r_width      <= abae_pkg::WIDTH_INIT;
            r_cnt        <= CW'(RB);
            r_bw         <= '0;
            r_fault_seen <= 1'b0;
            r_clr_end    <= 1'b0;
            r_fs_end     <= 1'b0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
            r_div_cnt    <= '0;
            r_flush_k    <= '0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ctx_vld    <= n_ctx_vld;
            r_low        <= n_low;
            r_width      <= n_width;
            r_cnt        <= n_cnt;
            r_bw         <= n_bw;
            r_fault_seen <= n_fault_seen;
            r_clr_end    <= n_clr_end;
            r_fs_end     <= n_fs_end;
            r_pend_v     <= n_pend_v;
            r_out_v      <= n_out_v;
            r_div_cnt    <= n_div_cnt;
            r_flush_k    <= n_flush_k;
            r_rd_vld     <= n_rd_vld;
        end
        r_cmd     <= n_cmd;
        r_bit     <= n_bit;
        r_node    <= n_node;
        r_pair    <= n_pair;
        r_pos     <= n_pos;
        r_rem     <= n_rem;
        r_dvd     <= n_dvd;
        r_quo     <= n_quo;
        r_div_n   <= n_div_n;
        r_fstat   <= n_fstat;
        r_flush_v <= n_flush_v;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    `ABAE_ASSERT(a_idle_no_pend, (r_state == ST_IDLE) |-> !r_pend_v, "held result left over in idle")
    `ABAE_ASSERT(a_coded_ok, (r_out_v && r_out.byte_valid) |-> (r_out.status == abae_pkg::STAT_OK), "coded word with fault status")
    `ABAE_ASSERT(a_phase_nonzero, (r_state == ST_RENORM) |-> (r_cnt != '0), "shift phase counter reached zero")

endmodule
`default_nettype wire

@@ design/adaptive_binary_arith_encoder.sv @@
// Channel   Ports                              Moves
// input     i_in, i_in_valid, o_in_ready       source word: data_byte, last_byte
// output    o_out, o_out_valid, i_out_ready    result word: coded byte or status
// config    i_cfg_we, i_cfg_data               out_limit, written at once
//
// A word passes through the front queue, then the coder takes it and, for each
// source bit, runs a context read, split setup, four divider steps, an update and
// a range check with any renormalizing shifts, then finishes. A last word adds the
// room check and four flush words. Reset is synchronous and needs no clearing pass.
// A stalled output holds the coder wherever a word is due, and the two-word queue
// keeps taking input meanwhile until it is full.
`default_nettype none
module adaptive_binary_arith_encoder (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire abae_pkg::t_in   i_in,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output abae_pkg::t_out       o_out,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire logic            i_cfg_we,
    input  wire logic [23:0]     i_cfg_data
);

    logic [23:0]    r_out_limit;
    abae_pkg::t_cmd cmd;
    logic           cmd_valid, cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_limit <= abae_pkg::LIMIT_INIT;
        end else if (i_cfg_we) begin
            r_out_limit <= i_cfg_data;
        end
    end

    abae_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    abae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_out_limit (r_out_limit),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule
`default_nettype wire

@@ tb/sv/arith_encoder_checker.sv @@
`default_nettype none
module arith_encoder_checker (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire abae_pkg::t_in   i_in,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_ready,
    input  wire abae_pkg::t_out  i_out,
    input  wire logic            i_out_valid,
    input  wire logic            i_out_ready,
    input  wire logic            i_cfg_we,
    input  wire logic [23:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] LOW_MASK = 64'(abae_pkg::RANGE_MASK);

    abae_pkg::t_out expected_words[$];

    logic [15:0] ctx_pairs[256];
    logic [63:0] code_low;
    logic [31:0] code_width;
    int          code_phase;
    logic [23:0] bytes_out;
    int          bytes_in;
    logic        stream_faulted;
    logic [23:0] limit_reg;

    assign o_pending = expected_words.size();

    function automatic void clear_stream();
        foreach (ctx_pairs[i]) ctx_pairs[i] = '0;
        code_low       = '0;
        code_width     = 32'(abae_pkg::WIDTH_INIT);
        code_phase     = -abae_pkg::RANGE_BITS;
        bytes_out      = '0;
        bytes_in       = 0;
        stream_faulted = 1'b0;
    endfunction

    function automatic void add_word(logic [7:0] b, logic v, logic e, logic [1:0] s);
        abae_pkg::t_out w;
        w.coded_byte = b;
        w.byte_valid = v;
        w.run_last   = 1'b0;
        w.stream_end = e;
        w.status     = s;
        expected_words.push_back(w);
    endfunction

    // Signed split: positive is the zero share, negative is minus the one share.
    function automatic int split_share(logic [15:0] pair);
        int z, o, n, d;
        z = int'(pair[15:8]);
        o = int'(pair[7:0]);
        n = z + o + 2;
        if (z < o) begin
            d = 175 * (z + 1) / n;
            if (d == 0) d = 1;
        end else begin
            d = -(175 * (o + 1) / n);
            if (d == 0) d = -1;
        end
        return d;
    endfunction

    function automatic logic [15:0] count_bit(logic [15:0] pair, logic bit_val);
        logic [7:0] z, o;
        z = pair[15:8];
        o = pair[7:0];
        if (bit_val) begin
            if (o != 8'd255) o++; else begin o = abae_pkg::COUNT_HALF; z = z >> 1; end
        end else begin
            if (z != 8'd255) z++; else begin z = abae_pkg::COUNT_HALF; o = o >> 1; end
        end
        return {z, o};
    endfunction

    function automatic logic [1:0] encode_byte(logic [7:0] b);
        logic [7:0]  node;
        logic [15:0] pair;
        logic        bit_val;
        int          share;
        logic [31:0] mag;
        node = 8'd1;
        for (int k = 7; k >= 0; k--) begin
            bit_val = b[k];
            pair  = ctx_pairs[node];
            share = split_share(pair);
            mag   = 32'(share > 0 ? share : -share);
            if (code_width <= mag) return abae_pkg::STAT_COLLAPSE;
            if ((share > 0) != bit_val) begin
                code_low  += 64'(code_width - mag);
                code_width = mag;
            end else begin
                code_width -= mag;
            end
            ctx_pairs[node] = count_bit(pair, bit_val);
            node = {node[6:0], bit_val};
            while (code_width < 32'(abae_pkg::RENORM_MIN)) begin
                if (code_width == 0) return abae_pkg::STAT_COLLAPSE;
                code_width = code_width << 1;
                code_low   = code_low << 1;
                code_phase++;
                if (code_phase == 0) begin
                    code_phase = -8;
                    if (bytes_out >= limit_reg) return abae_pkg::STAT_LIMIT;
                    add_word(code_low[abae_pkg::RANGE_BITS +: 8], 1'b1, 1'b0,
                             abae_pkg::STAT_OK);
                    bytes_out++;
                    code_low &= LOW_MASK;
                    if (LOW_MASK - code_low < 64'(code_width))
                        code_width = 32'(LOW_MASK - code_low);
                end
            end
        end
        return abae_pkg::STAT_OK;
    endfunction

    function automatic void predict_coded_words(abae_pkg::t_in w);
        int          n0;
        logic [1:0]  f;
        logic [63:0] v;
        n0 = expected_words.size();
        if (stream_faulted) begin
            if (w.last_byte) clear_stream();
            return;
        end
        if (bytes_in < 3) bytes_in++;
        if (w.last_byte && bytes_in < 3) begin
            add_word(8'd0, 1'b0, 1'b1, abae_pkg::STAT_SHORT);
            clear_stream();
        end else begin
            f = encode_byte(w.data_byte);
            if (f != abae_pkg::STAT_OK) begin
                add_word(8'd0, 1'b0, 1'b1, f);
                if (w.last_byte) clear_stream();
                else stream_faulted = 1'b1;
            end else if (w.last_byte) begin
                if (bytes_out >= limit_reg || limit_reg - bytes_out < 24'd4) begin
                    add_word(8'd0, 1'b0, 1'b1, abae_pkg::STAT_LIMIT);
                end else begin
                    v = code_low << (8 - code_phase[2:0]);
                    for (int k = 0; k < 4; k++)
                        add_word(8'(v >> (abae_pkg::RANGE_BITS - 8 * k)), 1'b1, k == 3,
                                 abae_pkg::STAT_OK);
                end
                clear_stream();
            end
        end
        if (expected_words.size() > n0)
            expected_words[expected_words.size() - 1].run_last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        abae_pkg::t_out want;
        if (!i_rst_n) begin
            expected_words.delete();
            clear_stream();
            limit_reg    = abae_pkg::LIMIT_INIT;
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) limit_reg = i_cfg_data;
            if (i_in_valid && i_in_ready) predict_coded_words(i_in);
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word %p", i_out);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_out.coded_byte !== want.coded_byte) begin
                        $error("coded_byte expected %0h actual %0h",
                               want.coded_byte, i_out.coded_byte);
                        o_fail_count++;
                    end
                    if (i_out.byte_valid !== want.byte_valid) begin
                        $error("byte_valid expected %0d actual %0d",
                               want.byte_valid, i_out.byte_valid);
                        o_fail_count++;
                    end
                    if (i_out.run_last !== want.run_last) begin
                        $error("run_last expected %0d actual %0d",
                               want.run_last, i_out.run_last);
                        o_fail_count++;
                    end
                    if (i_out.stream_end !== want.stream_end) begin
                        $error("stream_end expected %0d actual %0d",
                               want.stream_end, i_out.stream_end);
                        o_fail_count++;
                    end
                    if (i_out.status !== want.status) begin
                        $error("status expected %0d actual %0d",
                               want.status, i_out.status);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ tb/sv/tb_adaptive_binary_arith_encoder.sv @@
`default_nettype none
module tb_adaptive_binary_arith_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    abae_pkg::t_in  in_word = '0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    abae_pkg::t_out out_word;
    logic           out_valid;
    logic           out_ready = 1'b0;
    logic           cfg_we = 1'b0;
    logic [23:0]    cfg_data = '0;
    int             fail_count;
    int             pending;

    int   send_idle = 36;
    int   recv_idle = 83;
    logic hold_go = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_cnt = 0;
    int   quiet_cycles = 0;

    adaptive_binary_arith_encoder uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_word), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .o_out(out_word), .o_out_valid(out_valid), .i_out_ready(out_ready),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    arith_encoder_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_word), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_out(out_word), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_cnt   <= 600;
            hold_taken <= 1'b1;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic lst);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        in_valid          <= 1'b1;
        in_word.data_byte <= b;
        in_word.last_byte <= lst;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [23:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly full-length streams; some skewed toward one byte value so the
    // contexts adapt strongly, and a few too short to code.
    task automatic random_stream(output int sent);
        int         len;
        logic [7:0] fav;
        bit         skewed;
        len    = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(12, 3);
        skewed = 1'($urandom_range(1));
        fav    = 8'($urandom);
        for (int k = 0; k < len; k++)
            send_word((skewed && $urandom_range(7) != 0) ? fav : 8'($urandom), k == len - 1);
        sent = len;
    endtask

    task automatic random_phase(input int items);
        int done, n;
        done = 0;
        while (done < items) begin
            random_stream(n);
            done += n;
            if ($urandom_range(19) == 0) begin
                // Sender pauses until every expected word is back.
                in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h55, 1'b1);
        send_word(8'hAA, 1'b1);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b1);
        repeat (6) send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);

        // A zero limit faults on the first coded byte; the rest is dropped.
        set_limit(24'd0);
        for (int k = 0; k < 5; k++) send_word(8'($urandom), k == 4);
        // A small limit leaves no room for the flush.
        set_limit(24'd5);
        for (int k = 0; k < 5; k++) send_word(8'h3C ^ 8'(k), k == 4);
        set_limit(24'hFFFFFF);

        hold_go <= 1'b1;
        random_phase(160);
        set_limit(24'($urandom_range(40, 4)));
        send_idle = 83;
        recv_idle = 36;
        random_phase(150);
        set_limit(24'($urandom));
        send_idle = 0;
        recv_idle = 0;
        random_phase(70);
        set_limit(24'hFFFFFF);
        random_phase(70);

        drain();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+design
design/abae_pkg.sv
design/abae_front.sv
design/abae_back.sv
design/adaptive_binary_arith_encoder.sv
tb/sv/arith_encoder_checker.sv
tb/sv/tb_adaptive_binary_arith_encoder.sv
